@@ rtl/nge_pkg.sv @@
package nge_pkg;
    localparam int unsigned DEPTH_DEF = 1024;
    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
endpackage

@@ rtl/nge_ram.sv @@
module nge_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/nge_front.sv @@
module nge_front #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_mode,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_last,
    output logic                  o_q_valid,
    output logic [VALUE_BITS+1:0] o_q_word,
    input  logic                  i_q_take
);
    localparam int unsigned QD = 2;
    logic [VALUE_BITS+1:0] r_buf [QD];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  w_in, w_out;

    assign o_full    = (r_cnt == 2'(QD));
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_buf[r_rp];
    assign w_in      = i_push && !o_full;
    assign w_out     = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_buf[r_wp] <= {i_mode, i_last, i_value};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end
endmodule

@@ rtl/nge_back.sv @@
module nge_back #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [VALUE_BITS+1:0] i_q_word,
    output logic                  o_q_take,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [VALUE_BITS-1:0] o_greater_value,
    output logic                  o_has_greater,
    output logic                  o_found
);
    import nge_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PASS_RD, S_PASS_CMP, S_QRY_RD, S_QRY_CMP, S_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt, r_sp;
    logic          r_ready;
    logic [AW:0]   r_i;
    logic [VALUE_BITS-1:0] r_cur, r_key;
    logic [VALUE_BITS-1:0] r_gv;
    logic r_hg, r_fd;
    logic r_wait;

    logic w_mode, w_last;
    logic [VALUE_BITS-1:0] w_val;
    assign w_mode = i_q_word[VALUE_BITS+1];
    assign w_last = i_q_word[VALUE_BITS];
    assign w_val  = i_q_word[VALUE_BITS-1:0];

    logic ref_we; logic [AW-1:0] ref_wa, ref_ra; logic [VALUE_BITS-1:0] ref_wd, ref_rd;
    logic gt_we; logic [AW-1:0] gt_wa; logic [VALUE_BITS:0] gt_wd, gt_rd;
    logic st_we; logic [AW-1:0] st_wa, st_ra;
    logic [VALUE_BITS-1:0] st_wd, st_rd;

    nge_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ref (
        .i_clk, .i_we(ref_we), .i_waddr(ref_wa), .i_wdata(ref_wd),
        .i_raddr(ref_ra), .o_rdata(ref_rd));
    nge_ram #(.WIDTH(VALUE_BITS + 1), .DEPTH(DEPTH)) u_gt (
        .i_clk, .i_we(gt_we), .i_waddr(gt_wa), .i_wdata(gt_wd),
        .i_raddr(ref_ra), .o_rdata(gt_rd));
    nge_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_stk (
        .i_clk, .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd));

    logic w_top_gt;
    assign w_top_gt = $signed(st_rd) > $signed(r_cur);

    always_comb begin
        o_q_take = 1'b0;
        ref_we = 1'b0; ref_wa = r_cnt[AW-1:0]; ref_wd = w_val;
        ref_ra = r_i[AW-1:0];
        gt_we = 1'b0; gt_wa = r_i[AW-1:0]; gt_wd = '0;
        st_we = 1'b0; st_wa = r_sp[AW-1:0]; st_wd = r_cur;
        st_ra = AW'(r_sp - CW'(1));
        unique case (r_state)
            S_IDLE: begin
                o_q_take = i_q_valid;
                if (i_q_valid && w_mode == MODE_LOAD) begin
                    ref_we = r_ready ? 1'b1 : (r_cnt < CW'(DEPTH));
                    ref_wa = r_ready ? '0 : r_cnt[AW-1:0];
                end
            end
            S_PASS_RD: begin
                ref_ra = AW'(r_i - (AW+1)'(1));
            end
            S_PASS_CMP: begin
                if (r_wait) begin
                end else if (r_sp == '0 || w_top_gt) begin
                    gt_we = 1'b1;
                    gt_wd = (r_sp == '0) ? {1'b0, {VALUE_BITS{1'b1}}} : {1'b1, st_rd};
                    st_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sp    <= '0;
            r_ready <= 1'b0;
            r_wait  <= 1'b0;
            r_i     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (w_mode == MODE_LOAD) begin
                            logic [CW-1:0] nc;
                            nc = r_ready ? CW'(1)
                               : ((r_cnt < CW'(DEPTH)) ? r_cnt + CW'(1) : r_cnt);
                            r_cnt   <= nc;
                            r_ready <= 1'b0;
                            if (w_last) begin
                                r_i     <= (AW+1)'(nc);
                                r_sp    <= '0;
                                r_state <= S_PASS_RD;
                            end
                        end else begin
                            r_key <= w_val;
                            r_i   <= '0;
                            r_gv  <= '1;
                            r_hg  <= 1'b0;
                            r_fd  <= 1'b0;
                            r_state <= (r_ready && r_cnt != '0) ? S_QRY_RD : S_OUT;
                        end
                    end
                end
                S_PASS_RD: begin
                    if (r_i == '0) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_wait  <= 1'b1;
                        r_state <= S_PASS_CMP;
                    end
                end
                S_PASS_CMP: begin
                    if (r_wait) begin
                        r_cur  <= ref_rd;
                        r_wait <= 1'b0;
                    end else if (r_sp == '0 || w_top_gt) begin
                        r_sp    <= r_sp + CW'(1);
                        r_state <= S_PASS_RD;
                    end else begin
                        r_sp <= r_sp - CW'(1);
                        r_wait <= 1'b1;
                    end
                end
                S_QRY_RD: begin
                    r_state <= S_QRY_CMP;
                end
                S_QRY_CMP: begin
                    if (ref_rd == r_key) begin
                        r_gv <= gt_rd[VALUE_BITS-1:0];
                        r_hg <= gt_rd[VALUE_BITS];
                        r_fd <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_i + 1'b1 >= (AW+1)'(r_cnt)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_QRY_RD;
                    end
                end
                S_OUT: begin
                    if (i_pop) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty         = (r_state != S_OUT);
    assign o_greater_value = r_gv;
    assign o_has_greater   = r_hg;
    assign o_found         = r_fd;
endmodule

@@ rtl/next_greater_element_engine.sv @@
// Next greater element engine.
// Input channel: push/full queue with mode, value and last. Mode 0 loads
// one element of the reference sequence; the load marked last starts a
// right-to-left monotonic stack pass over the stored elements. Mode 1
// queries a value and yields one result word.
// Result channel: empty/pop queue with greater_value, has_greater, found.
// A two-word queue sits between the intake and the engine.
// Loads are written to the value memory from the idle state. The pass
// reads each element, compares it with the stack top, pops while the top
// is not greater, then records the answer and pushes the element; the
// value and stack memories have registered read ports. A query scans the
// sequence left to right, a registered read then a compare per element.
// A result waits on the ports until popped; while it waits the engine
// holds and the intake queue fills, then full rises.
// Reset clears the sequence length and ready flag; queries before a pass
// answer found = 0, has_greater = 0, greater_value = -1.
module next_greater_element_engine
    #(
    parameter int unsigned DEPTH = nge_pkg::DEPTH_DEF,
    parameter int unsigned VALUE_BITS = nge_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_mode,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [VALUE_BITS-1:0] o_greater_value,
    output logic                  o_has_greater,
    output logic                  o_found
);
    import nge_pkg::*;
    logic q_valid, q_take;
    logic [VALUE_BITS+1:0] q_word;

    nge_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_mode, .i_value,
        .i_last, .o_q_valid(q_valid), .o_q_word(q_word), .i_q_take(q_take));

    nge_back #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_word(q_word),
        .o_q_take(q_take), .o_empty(empty), .i_pop(pop), .o_greater_value,
        .o_has_greater, .o_found);
endmodule
